[sv/icrt_pkg.sv]
// Shared constants, codes and handshake structs for the image chunk receive tracker.
`timescale 1ns / 1ps

package icrt_pkg;

    // Sizing of the session and the chunk bitmap.
    localparam int MAX_IMAGE_BYTES = 262144;
    localparam int SLOT_BYTES      = 262144;
    localparam int CHUNK_BYTES     = 256;
    localparam int LIMIT_BYTES     = (MAX_IMAGE_BYTES < SLOT_BYTES) ? MAX_IMAGE_BYTES : SLOT_BYTES;
    localparam int MAX_CHUNKS      = (MAX_IMAGE_BYTES + CHUNK_BYTES - 1) / CHUNK_BYTES;
    localparam int CHUNK_SH        = $clog2(CHUNK_BYTES);
    localparam int SIZE_W          = $clog2(LIMIT_BYTES + 1);
    localparam int CNT_W           = $clog2(MAX_CHUNKS + 1);
    localparam int IDX_W           = $clog2(MAX_CHUNKS);
    localparam int ROW_BITS        = 32;
    localparam int COL_W           = $clog2(ROW_BITS);
    localparam int ROWS            = (MAX_CHUNKS + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_W           = (ROWS > 1) ? $clog2(ROWS) : 1;

    // CRC-32, reflected form.
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // Command codes.
    localparam logic [2:0] CMD_BEGIN  = 3'd0;
    localparam logic [2:0] CMD_CHUNK  = 3'd1;
    localparam logic [2:0] CMD_END    = 3'd2;
    localparam logic [2:0] CMD_VERIFY = 3'd3;
    localparam logic [2:0] CMD_ABORT  = 3'd4;
    localparam logic [2:0] CMD_STATUS = 3'd5;

    // Session phases.
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_RECV    = 3'd1;
    localparam logic [2:0] PH_VERIFY  = 3'd2;
    localparam logic [2:0] PH_READY   = 3'd3;
    localparam logic [2:0] PH_ABORTED = 3'd4;
    localparam logic [2:0] PH_ERROR   = 3'd5;

    // Status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BUSY    = 3'd1;
    localparam logic [2:0] ST_SIZE    = 3'd2;
    localparam logic [2:0] ST_STATE   = 3'd3;
    localparam logic [2:0] ST_PARAM   = 3'd4;
    localparam logic [2:0] ST_MISSING = 3'd5;
    localparam logic [2:0] ST_CRC     = 3'd6;

    // Bitmap requests and responses.
    typedef struct packed {
        logic             clear;
        logic             mark;
        logic [IDX_W-1:0] idx;
    } bm_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic             was_new;
        logic [CNT_W-1:0] ptr;
    } bm_rsp_t;

    // CRC unit requests and responses.
    typedef struct packed {
        logic        start;
        logic [31:0] crc;
        logic [7:0]  data;
    } crc_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] crc;
    } crc_rsp_t;

endpackage

[sv/icrt_in_if.sv]
// Command channel interface: valid, ready and the command payload.
`timescale 1ns / 1ps

interface icrt_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [31:0] image_bytes;
    logic [31:0] expected_crc;
    logic [31:0] chunk_offset;
    logic [15:0] chunk_length;
    logic [7:0]  verify_data;

    modport source (output valid, cmd, image_bytes, expected_crc, chunk_offset,
                    chunk_length, verify_data, input ready);
    modport sink (input valid, cmd, image_bytes, expected_crc, chunk_offset,
                  chunk_length, verify_data, output ready);
endinterface

[sv/icrt_out_if.sv]
// Result channel interface: valid, ready and the status payload.
`timescale 1ns / 1ps

interface icrt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status_code;
    logic [2:0]  phase_out;
    logic        write_needed;
    logic [18:0] gap_offset;
    logic [10:0] blocks_done;
    logic [18:0] bytes_done;
    logic [10:0] blocks_total;
    logic [2:0]  error_latched;

    modport source (output valid, status_code, phase_out, write_needed, gap_offset,
                    blocks_done, bytes_done, blocks_total, error_latched, input ready);
    modport sink (input valid, status_code, phase_out, write_needed, gap_offset,
                  blocks_done, bytes_done, blocks_total, error_latched, output ready);
endinterface

[sv/icrt_crc_unit.sv]
// Bit-serial CRC-32 unit: folds one byte into the running CRC.
`timescale 1ns / 1ps

module icrt_crc_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  icrt_pkg::crc_req_t req,
    output icrt_pkg::crc_rsp_t rsp
);
    import icrt_pkg::*;

    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic [2:0]  cnt_reg;
    logic [2:0]  cnt_next;
    logic        busy_reg;
    logic        busy_next;
    logic        done_reg;
    logic        done_next;

    // One polynomial step per cycle while busy.
    always_comb
    begin
        crc_next  = crc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            crc_next = crc_reg[0] ? ((crc_reg >> 1) ^ CRC_POLY) : (crc_reg >> 1);
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            crc_next  = req.crc ^ {24'd0, req.data};
            cnt_next  = 3'd0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 3'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // The CRC value itself is payload.
    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.crc  = crc_reg;

endmodule

[sv/icrt_bitmap.sv]
// Chunk bitmap memory with clear sweep, test-and-set and first-missing pointer scan.
`timescale 1ns / 1ps

module icrt_bitmap (
    input  logic              clk,
    input  logic              rst_n,
    input  icrt_pkg::bm_req_t req,
    output icrt_pkg::bm_rsp_t rsp
);
    import icrt_pkg::*;

    localparam logic [2:0] BM_IDLE    = 3'd0;
    localparam logic [2:0] BM_CLEAR   = 3'd1;
    localparam logic [2:0] BM_MARK    = 3'd2;
    localparam logic [2:0] BM_SCAN_RD = 3'd3;
    localparam logic [2:0] BM_SCAN    = 3'd4;

    logic [ROW_BITS-1:0] mem [ROWS];

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [ROW_W-1:0]    row_cnt_reg;
    logic [ROW_W-1:0]    row_cnt_next;
    logic [CNT_W-1:0]    ptr_reg;
    logic [CNT_W-1:0]    ptr_next;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;
    logic                done_reg;
    logic                done_next;
    logic                new_reg;
    logic                new_next;
    logic [ROW_BITS-1:0] rd_data_reg;

    logic [ROW_W-1:0]    rd_addr;
    logic                wr_en;
    logic [ROW_W-1:0]    wr_addr;
    logic [ROW_BITS-1:0] wr_data;
    logic [ROW_W-1:0]    mark_row;
    logic [COL_W-1:0]    mark_col;
    logic                hit;
    logic [ROW_BITS-1:0] marked;
    logic [ROW_BITS-1:0] scan_word;
    logic [COL_W-1:0]    scan_start;
    logic [ROW_W-1:0]    scan_row;
    logic [ROW_BITS-1:0] free_bits;
    logic                found;
    logic [CNT_W-1:0]    scan_ptr;
    logic                last_row;

    // Lowest set bit of one bitmap row.
    function automatic logic [COL_W-1:0] low_one(input logic [ROW_BITS-1:0] v);
        logic [COL_W-1:0] r;
        r = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = COL_W'(i);
            end
        end
        return r;
    endfunction

    // Row and bit of the chunk being marked.
    assign mark_row = idx_reg[IDX_W-1:COL_W];
    assign mark_col = idx_reg[COL_W-1:0];
    assign hit      = rd_data_reg[mark_col];
    assign marked   = rd_data_reg | (ROW_BITS'(1) << mark_col);

    // Scan step: the first clear bit at or after the start column of one row.
    assign scan_word  = (state_reg == BM_MARK) ? marked : rd_data_reg;
    assign scan_start = (state_reg == BM_MARK) ? mark_col : '0;
    assign scan_row   = (state_reg == BM_MARK) ? mark_row : ptr_reg[IDX_W-1:COL_W];
    assign free_bits  = ~scan_word & ({ROW_BITS{1'b1}} << scan_start);
    assign found      = |free_bits;
    assign last_row   = (scan_row == ROW_W'(ROWS - 1));
    assign scan_ptr   = found ? CNT_W'({scan_row, low_one(free_bits)})
                              : CNT_W'({(ROW_W + 1)'(scan_row) + (ROW_W + 1)'(1),
                                        {COL_W{1'b0}}});

    // Memory addressing.
    assign rd_addr = (state_reg == BM_IDLE) ? req.idx[IDX_W-1:COL_W] : ptr_reg[IDX_W-1:COL_W];
    assign wr_en   = (state_reg == BM_CLEAR) || ((state_reg == BM_MARK) && !hit);
    assign wr_addr = (state_reg == BM_CLEAR) ? row_cnt_reg : mark_row;
    assign wr_data = (state_reg == BM_CLEAR) ? '0 : marked;

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        row_cnt_next = row_cnt_reg;
        ptr_next     = ptr_reg;
        idx_next     = idx_reg;
        done_next    = 1'b0;
        new_next     = new_reg;
        case (state_reg)
            BM_IDLE:
            begin
                if (req.clear)
                begin
                    state_next   = BM_CLEAR;
                    row_cnt_next = '0;
                    ptr_next     = '0;
                end
                else if (req.mark)
                begin
                    idx_next   = req.idx;
                    state_next = BM_MARK;
                end
            end
            BM_CLEAR:
            begin
                row_cnt_next = row_cnt_reg + ROW_W'(1);
                if (row_cnt_reg == ROW_W'(ROWS - 1))
                begin
                    state_next = BM_IDLE;
                    done_next  = 1'b1;
                end
            end
            BM_MARK:
            begin
                new_next = !hit;
                if (!hit && (CNT_W'(idx_reg) == ptr_reg))
                begin
                    ptr_next = scan_ptr;
                    if (found || last_row)
                    begin
                        state_next = BM_IDLE;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = BM_SCAN_RD;
                    end
                end
                else
                begin
                    state_next = BM_IDLE;
                    done_next  = 1'b1;
                end
            end
            BM_SCAN_RD:
            begin
                state_next = BM_SCAN;
            end
            BM_SCAN:
            begin
                ptr_next = scan_ptr;
                if (found || last_row)
                begin
                    state_next = BM_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    state_next = BM_SCAN_RD;
                end
            end
            default:
            begin
                state_next = BM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BM_IDLE;
            row_cnt_reg <= '0;
            ptr_reg     <= '0;
            done_reg    <= 1'b0;
            new_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            row_cnt_reg <= row_cnt_next;
            ptr_reg     <= ptr_next;
            done_reg    <= done_next;
            new_reg     <= new_next;
        end
    end

    // Bitmap storage with a registered read port.
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        rd_data_reg <= mem[rd_addr];
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rsp.busy    = (state_reg != BM_IDLE);
    assign rsp.done    = done_reg;
    assign rsp.was_new = new_reg;
    assign rsp.ptr     = ptr_reg;

endmodule

[sv/image_chunk_receive_tracker.sv]
// Top level of the image chunk receive tracker: command sequencer and result register.
//
//  Channel | Dir | Payload                                                | Transfer when
//  in_ch   | in  | cmd, image_bytes, expected_crc, chunk_offset, length, data | valid & ready
//  out_ch  | out | status, phase, write flag, offsets, counts, error        | valid & ready
//
// Status, abort, end and rejected commands go from execute straight to the result; a
// verify byte waits for the bit-serial CRC unit. Begin waits for the bitmap clear sweep
// of 32 rows. A new chunk that fills the first gap also scans bitmap rows, each with a
// read step and a scan step.
// After reset a clear sweep of the bitmap runs before the first command is taken.
// The next command is taken while a result still waits in the output register.
`timescale 1ns / 1ps

module image_chunk_receive_tracker (
    input logic       clk,
    input logic       rst_n,
    icrt_in_if.sink   in_ch,
    icrt_out_if.source out_ch
);
    import icrt_pkg::*;

    localparam logic [2:0] S_INIT      = 3'd0;
    localparam logic [2:0] S_INIT_WAIT = 3'd1;
    localparam logic [2:0] S_IDLE      = 3'd2;
    localparam logic [2:0] S_EXEC      = 3'd3;
    localparam logic [2:0] S_WAIT_BM   = 3'd4;
    localparam logic [2:0] S_WAIT_CRC  = 3'd5;
    localparam logic [2:0] S_DONE      = 3'd6;

    typedef struct packed {
        logic [2:0]        phase;
        logic [CNT_W-1:0]  seen_count;
        logic [SIZE_W-1:0] seen_bytes;
        logic [SIZE_W-1:0] size;
        logic [31:0]       crc;
        logic [31:0]       crc_run;
        logic [SIZE_W-1:0] vcount;
        logic [2:0]        err;
    } sess_t;

    typedef struct packed {
        logic [2:0]        status_code;
        logic [2:0]        phase_out;
        logic              write_needed;
        logic [SIZE_W-1:0] gap_offset;
        logic [CNT_W-1:0]  blocks_done;
        logic [SIZE_W-1:0] bytes_done;
        logic [CNT_W-1:0]  blocks_total;
        logic [2:0]        error_latched;
    } res_t;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    sess_t             sess_reg;
    sess_t             sess_next;
    logic [2:0]        st_reg;
    logic [2:0]        st_next;
    logic              wr_reg;
    logic              wr_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    res_t              res_reg;
    res_t              res_next;

    logic [2:0]        cmd_reg;
    logic [31:0]       size_in_reg;
    logic [31:0]       crc_in_reg;
    logic [31:0]       off_reg;
    logic [15:0]       len_reg;
    logic [7:0]        data_reg;

    bm_req_t           bm_req;
    bm_rsp_t           bm_rsp;
    crc_req_t          crc_req;
    crc_rsp_t          crc_rsp;

    logic              in_xfer;
    logic [CNT_W-1:0]  total;
    logic [31:0]       remain;
    logic [SIZE_W-1:0] vcount_inc;
    logic [SIZE_W-1:0] next_off;

    icrt_bitmap u_bitmap (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (bm_req),
        .rsp   (bm_rsp)
    );

    icrt_crc_unit u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (crc_req),
        .rsp   (crc_rsp)
    );

    // Derived session values.
    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign total       = CNT_W'(((SIZE_W + 1)'(sess_reg.size) + (SIZE_W + 1)'(CHUNK_BYTES - 1))
                                >> CHUNK_SH);
    assign remain      = 32'(sess_reg.size) - off_reg;
    assign vcount_inc  = sess_reg.vcount + SIZE_W'(1);
    assign next_off    = (bm_rsp.ptr < total) ? SIZE_W'({bm_rsp.ptr, {CHUNK_SH{1'b0}}})
                                              : sess_reg.size;

    // Command sequencer.
    always_comb
    begin
        state_next     = state_reg;
        sess_next      = sess_reg;
        st_next        = st_reg;
        wr_next        = wr_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        bm_req         = '0;
        bm_req.idx     = off_reg[CHUNK_SH +: IDX_W];
        crc_req.start  = 1'b0;
        crc_req.crc    = (sess_reg.vcount >= sess_reg.size) ? CRC_INIT : sess_reg.crc_run;
        crc_req.data   = data_reg;
        case (state_reg)
            S_INIT:
            begin
                bm_req.clear = 1'b1;
                state_next   = S_INIT_WAIT;
            end
            S_INIT_WAIT:
            begin
                if (bm_rsp.done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    st_next    = ST_OK;
                    wr_next    = 1'b0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (cmd_reg)
                    CMD_BEGIN:
                    begin
                        if ((sess_reg.phase == PH_RECV) || (sess_reg.phase == PH_VERIFY) ||
                            (sess_reg.phase == PH_READY))
                        begin
                            st_next = ST_BUSY;
                        end
                        else if ((size_in_reg == 32'd0) || (size_in_reg > 32'(LIMIT_BYTES)))
                        begin
                            st_next = ST_SIZE;
                        end
                        else
                        begin
                            sess_next.size       = SIZE_W'(size_in_reg);
                            sess_next.crc        = crc_in_reg;
                            sess_next.phase      = PH_RECV;
                            sess_next.err        = ST_OK;
                            sess_next.seen_count = '0;
                            sess_next.seen_bytes = '0;
                            sess_next.crc_run    = CRC_INIT;
                            sess_next.vcount     = '0;
                            bm_req.clear         = 1'b1;
                            state_next           = S_WAIT_BM;
                        end
                    end
                    CMD_CHUNK:
                    begin
                        if (sess_reg.phase != PH_RECV)
                        begin
                            st_next = ST_STATE;
                        end
                        else if ((len_reg == 16'd0) || (32'(len_reg) > 32'(CHUNK_BYTES)))
                        begin
                            st_next         = ST_PARAM;
                            sess_next.err   = ST_PARAM;
                            sess_next.phase = PH_ERROR;
                        end
                        else if ((off_reg >= 32'(sess_reg.size)) || (32'(len_reg) > remain))
                        begin
                            st_next         = ST_SIZE;
                            sess_next.err   = ST_SIZE;
                            sess_next.phase = PH_ERROR;
                        end
                        else if (off_reg[CHUNK_SH-1:0] != '0)
                        begin
                            st_next         = ST_PARAM;
                            sess_next.err   = ST_PARAM;
                            sess_next.phase = PH_ERROR;
                        end
                        else
                        begin
                            bm_req.mark = 1'b1;
                            state_next  = S_WAIT_BM;
                        end
                    end
                    CMD_END:
                    begin
                        if (sess_reg.phase != PH_RECV)
                        begin
                            st_next = ST_STATE;
                        end
                        else if (sess_reg.seen_count < total)
                        begin
                            st_next       = ST_MISSING;
                            sess_next.err = ST_MISSING;
                        end
                        else
                        begin
                            sess_next.phase   = PH_VERIFY;
                            sess_next.crc_run = CRC_INIT;
                            sess_next.vcount  = '0;
                        end
                    end
                    CMD_VERIFY:
                    begin
                        if ((sess_reg.phase != PH_VERIFY) && (sess_reg.phase != PH_READY))
                        begin
                            st_next = ST_STATE;
                        end
                        else
                        begin
                            // A finished pass restarts from the first byte.
                            if (sess_reg.vcount >= sess_reg.size)
                            begin
                                sess_next.vcount = '0;
                            end
                            crc_req.start = 1'b1;
                            state_next    = S_WAIT_CRC;
                        end
                    end
                    CMD_ABORT:
                    begin
                        sess_next.phase = PH_ABORTED;
                        sess_next.err   = ST_OK;
                    end
                    CMD_STATUS:
                    begin
                        st_next = ST_OK;
                    end
                    default:
                    begin
                        st_next = ST_PARAM;
                    end
                endcase
            end
            S_WAIT_BM:
            begin
                if (bm_rsp.done)
                begin
                    if ((cmd_reg == CMD_CHUNK) && bm_rsp.was_new)
                    begin
                        sess_next.seen_count = sess_reg.seen_count + CNT_W'(1);
                        sess_next.seen_bytes = sess_reg.seen_bytes + SIZE_W'(len_reg);
                        wr_next              = 1'b1;
                    end
                    state_next = S_DONE;
                end
            end
            S_WAIT_CRC:
            begin
                if (crc_rsp.done)
                begin
                    sess_next.crc_run = crc_rsp.crc;
                    sess_next.vcount  = vcount_inc;
                    if (vcount_inc >= sess_reg.size)
                    begin
                        if ((crc_rsp.crc ^ CRC_INIT) != sess_reg.crc)
                        begin
                            st_next         = ST_CRC;
                            sess_next.err   = ST_CRC;
                            sess_next.phase = PH_ERROR;
                        end
                        else
                        begin
                            sess_next.phase = PH_READY;
                            sess_next.err   = ST_OK;
                        end
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Load the result once the output register is free.
                if (!out_valid_reg || out_ch.ready)
                begin
                    res_next.status_code   = st_reg;
                    res_next.phase_out     = sess_reg.phase;
                    res_next.write_needed  = wr_reg;
                    res_next.gap_offset    = next_off;
                    res_next.blocks_done   = sess_reg.seen_count;
                    res_next.bytes_done    = sess_reg.seen_bytes;
                    res_next.blocks_total  = total;
                    res_next.error_latched = sess_reg.err;
                    out_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_INIT;
            sess_reg.phase   <= PH_IDLE;
            sess_reg.seen_count <= '0;
            sess_reg.seen_bytes <= '0;
            sess_reg.size    <= '0;
            sess_reg.crc     <= '0;
            sess_reg.crc_run <= CRC_INIT;
            sess_reg.vcount  <= '0;
            sess_reg.err     <= ST_OK;
            st_reg           <= ST_OK;
            wr_reg           <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sess_reg      <= sess_next;
            st_reg        <= st_next;
            wr_reg        <= wr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Command capture and result payload.
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (in_xfer)
        begin
            cmd_reg     <= in_ch.cmd;
            size_in_reg <= in_ch.image_bytes;
            crc_in_reg  <= in_ch.expected_crc;
            off_reg     <= in_ch.chunk_offset;
            len_reg     <= in_ch.chunk_length;
            data_reg    <= in_ch.verify_data;
        end
    end

    // Result channel.
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.status_code   = res_reg.status_code;
    assign out_ch.phase_out     = res_reg.phase_out;
    assign out_ch.write_needed  = res_reg.write_needed;
    assign out_ch.gap_offset    = res_reg.gap_offset;
    assign out_ch.blocks_done   = res_reg.blocks_done;
    assign out_ch.bytes_done    = res_reg.bytes_done;
    assign out_ch.blocks_total  = res_reg.blocks_total;
    assign out_ch.error_latched = res_reg.error_latched;

    // A chunk flagged for writing always reports success.
    a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.write_needed) |-> (res_reg.status_code == ST_OK))
        else $error("write flag set on a failed result");

    // Distinct chunks never exceed the chunks of the session.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sess_reg.seen_count <= total)
        else $error("seen chunk count above session total");

    // The CRC unit only runs while the sequencer waits for it.
    a_crc_owner: assert property (@(posedge clk) disable iff (!rst_n)
        crc_rsp.busy |-> (state_reg == S_WAIT_CRC))
        else $error("CRC unit busy outside verify");

    // The first-missing pointer stays within the bitmap.
    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bm_rsp.ptr <= CNT_W'(MAX_CHUNKS))
        else $error("bitmap pointer out of range");

endmodule
